// ===== rtl/snps_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding Nyquist peak search package
// Shared widths, constants and payload types for the sliding Nyquist-bin
// peak search block.
// ----------------------------------------------------------------------------
package snps_pkg;

    localparam int WINDOW_MAX = 4096;
    localparam int POS_W      = 24;

    localparam int SAMPLE_W = 8;
    localparam int CFG_W    = 13;
    localparam int START_W  = 24;
    localparam int MAG_W    = 20;

    localparam int ADDR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = SAMPLE_W + ADDR_W + 1;
    localparam int ABS_W  = (SUM_W > MAG_W) ? SUM_W : MAG_W + 1;

    localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(4096);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } in_t;

    typedef struct packed {
        logic               found;
        logic [START_W-1:0] best_start;
        logic [MAG_W-1:0]   best_magnitude;
    } out_t;

    typedef struct packed {
        logic                       en;
        logic [ADDR_W-1:0]          wr_addr;
        logic signed [SAMPLE_W-1:0] wr_data;
        logic [ADDR_W-1:0]          rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        logic                       drop;
        logic                       found;
        logic                       odd;
        logic                       old_odd;
        logic [POS_W-1:0]           start;
    } stage_t;

endpackage

// ===== rtl/sliding_nyquist_peak_search_top.sv =====
// ----------------------------------------------------------------------------
// Sliding Nyquist peak search
// The last sample waits in the update stage register, then its result is registered.
// Throughput: one sample per cycle while the result register can take a finished run;
// the window sum update is fed by one registered delay-line read per sample.
// Reset: control state clears and the window length returns to 4096; the delay
// line is not cleared, as it is only read after the current run writes it.
// ----------------------------------------------------------------------------
module sliding_nyquist_peak_search_top
    import snps_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_t              s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_t             m_data
);

    logic                       accept;
    logic                       advance;
    logic                       out_free;
    logic                       stage_valid;
    stage_t                     stage;
    mem_req_t                   mem_req;
    logic signed [SAMPLE_W-1:0] old_sample;

    assign advance = stage_valid && (!stage.last || out_free);
    assign s_ready = !stage_valid || advance;
    assign accept  = s_valid && s_ready;

    snps_window_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .in_data     (s_data),
        .advance     (advance),
        .mem_req     (mem_req),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    snps_delay_line u_delay (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (old_sample)
    );

    snps_peak_track u_peak (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear      (cfg_wr_en),
        .advance    (advance),
        .stage      (stage),
        .old_sample (old_sample),
        .m_ready    (m_ready),
        .out_free   (out_free),
        .m_valid    (m_valid),
        .m_data     (m_data)
    );

endmodule

// ===== rtl/snps_delay_line.sv =====
// ----------------------------------------------------------------------------
// Sample delay line
// Single-port-pair memory holding the most recent samples; the read is
// registered and returns the old contents on a same-address write.
// ----------------------------------------------------------------------------
module snps_delay_line
    import snps_pkg::*;
(
    input  logic                       aclk,
    input  mem_req_t                   req,
    output logic signed [SAMPLE_W-1:0] rd_data
);

    logic signed [SAMPLE_W-1:0] mem [WINDOW_MAX];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.en) begin
            mem[req.wr_addr] <= req.wr_data;
            rd_data_reg      <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/snps_window_ctrl.sv =====
// ----------------------------------------------------------------------------
// Window control
// Holds the window length, write pointer, fill count and position, drives
// the delay line and registers each request into the update stage.
// ----------------------------------------------------------------------------
module snps_window_ctrl
    import snps_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             accept,
    input  in_t              in_data,
    input  logic             advance,
    output mem_req_t         mem_req,
    output logic             stage_valid,
    output stage_t           stage
);

    logic [CFG_W-1:0]  cfg_len_reg, cfg_len_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              stage_valid_reg, stage_valid_next;
    stage_t            stage_reg, stage_next;

    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  fill_inc;
    logic [LEN_W-1:0]  ptr_ext;
    logic [ADDR_W-1:0] ptr_inc;
    logic [ADDR_W-1:0] rd_addr;

    always_comb begin
        if (cfg_len_reg == '0) begin
            len = LEN_W'(1);
        end else if (cfg_len_reg > WINDOW_MAX) begin
            len = LEN_W'(WINDOW_MAX);
        end else begin
            len = LEN_W'(cfg_len_reg);
        end

        fill_inc = (fill_reg == LEN_W'(WINDOW_MAX)) ? fill_reg : fill_reg + 1'b1;
        ptr_inc  = (ptr_reg == ADDR_W'(WINDOW_MAX - 1)) ? '0 : ptr_reg + 1'b1;
        ptr_ext  = LEN_W'(ptr_reg);
        if (ptr_ext >= len) begin
            rd_addr = ADDR_W'(ptr_ext - len);
        end else begin
            rd_addr = ADDR_W'(ptr_ext + LEN_W'(WINDOW_MAX) - len);
        end

        mem_req.en      = accept;
        mem_req.wr_addr = ptr_reg;
        mem_req.wr_data = in_data.sample;
        mem_req.rd_addr = rd_addr;

        cfg_len_next = cfg_len_reg;
        ptr_next     = ptr_reg;
        fill_next    = fill_reg;
        pos_next     = pos_reg;
        if (cfg_wr_en) begin
            cfg_len_next = cfg_wr_data;
            ptr_next     = '0;
            fill_next    = '0;
            pos_next     = '0;
        end else if (accept) begin
            if (in_data.last) begin
                ptr_next  = '0;
                fill_next = '0;
                pos_next  = '0;
            end else begin
                ptr_next  = ptr_inc;
                fill_next = fill_inc;
                pos_next  = pos_reg + 1'b1;
            end
        end

        if (accept) begin
            stage_valid_next = 1'b1;
        end else if (advance) begin
            stage_valid_next = 1'b0;
        end else begin
            stage_valid_next = stage_valid_reg;
        end

        stage_next = stage_reg;
        if (accept) begin
            stage_next.sample  = in_data.sample;
            stage_next.last    = in_data.last;
            stage_next.drop    = (fill_reg >= len);
            stage_next.found   = (fill_inc >= len);
            stage_next.odd     = pos_reg[0];
            stage_next.old_odd = pos_reg[0] ^ len[0];
            stage_next.start   = pos_reg + 1'b1 - POS_W'(len);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_len_reg     <= LEN_RESET;
            ptr_reg         <= '0;
            fill_reg        <= '0;
            pos_reg         <= '0;
            stage_valid_reg <= 1'b0;
        end else begin
            cfg_len_reg     <= cfg_len_next;
            ptr_reg         <= ptr_next;
            fill_reg        <= fill_next;
            pos_reg         <= pos_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        stage_reg <= stage_next;
    end

    assign stage_valid = stage_valid_reg;
    assign stage       = stage_reg;

    // The fill count never passes the delay line depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= LEN_W'(WINDOW_MAX))
        else $error("fill count exceeds delay line depth");

    // Until the delay line has wrapped, the write pointer tracks the fill count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg < LEN_W'(WINDOW_MAX) |-> ptr_reg == ADDR_W'(fill_reg))
        else $error("write pointer out of step with fill count");

endmodule

// ===== rtl/snps_peak_track.sv =====
// ----------------------------------------------------------------------------
// Peak tracker
// Updates the alternating window sum, keeps the largest magnitude and its
// start, and holds the result register.
// ----------------------------------------------------------------------------
module snps_peak_track
    import snps_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       clear,
    input  logic                       advance,
    input  stage_t                     stage,
    input  logic signed [SAMPLE_W-1:0] old_sample,
    input  logic                       m_ready,
    output logic                       out_free,
    output logic                       m_valid,
    output out_t                       m_data
);

    localparam logic [ABS_W-1:0] MAG_LIMIT = {{(ABS_W - MAG_W){1'b0}}, {MAG_W{1'b1}}};

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [ABS_W-1:0]        peak_mag_reg, peak_mag_next;
    logic [POS_W-1:0]        peak_start_reg, peak_start_next;
    logic                    m_valid_reg, m_valid_next;
    out_t                    m_data_reg, m_data_next;

    logic signed [SUM_W-1:0] new_ext, old_ext, new_w, old_w, sum_upd;
    logic [ABS_W-1:0]        mag;
    logic [ABS_W-1:0]        best_mag;
    logic [POS_W-1:0]        best_start;

    always_comb begin
        new_ext = {{(SUM_W - SAMPLE_W){stage.sample[SAMPLE_W-1]}}, stage.sample};
        old_ext = {{(SUM_W - SAMPLE_W){old_sample[SAMPLE_W-1]}}, old_sample};
        new_w   = stage.odd ? -new_ext : new_ext;
        if (stage.drop) begin
            old_w = stage.old_odd ? -old_ext : old_ext;
        end else begin
            old_w = '0;
        end
        sum_upd = sum_reg - old_w + new_w;
        mag     = ABS_W'(sum_upd[SUM_W-1] ? -sum_upd : sum_upd);

        best_mag   = peak_mag_reg;
        best_start = peak_start_reg;
        if (stage.found && (mag > peak_mag_reg)) begin
            best_mag   = mag;
            best_start = stage.start;
        end

        out_free = !m_valid_reg || m_ready;

        sum_next        = sum_reg;
        peak_mag_next   = peak_mag_reg;
        peak_start_next = peak_start_reg;
        if (clear) begin
            sum_next        = '0;
            peak_mag_next   = '0;
            peak_start_next = '0;
        end else if (advance) begin
            if (stage.last) begin
                sum_next        = '0;
                peak_mag_next   = '0;
                peak_start_next = '0;
            end else begin
                sum_next        = sum_upd;
                peak_mag_next   = best_mag;
                peak_start_next = best_start;
            end
        end

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (advance && stage.last) begin
            m_valid_next = 1'b1;
            if (stage.found) begin
                m_data_next.found          = 1'b1;
                m_data_next.best_start     = START_W'(best_start);
                m_data_next.best_magnitude = (best_mag > MAG_LIMIT) ? {MAG_W{1'b1}}
                                                                    : MAG_W'(best_mag);
            end else begin
                m_data_next.found          = 1'b0;
                m_data_next.best_start     = '0;
                m_data_next.best_magnitude = '0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg        <= '0;
            peak_mag_reg   <= '0;
            peak_start_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            sum_reg        <= sum_next;
            peak_mag_reg   <= peak_mag_next;
            peak_start_reg <= peak_start_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A finished run always presents its result on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && stage.last |=> m_valid_reg)
        else $error("finished run produced no result");

    // A run without a full window reports zero start and magnitude.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.found
            |-> m_data_reg.best_start == '0 && m_data_reg.best_magnitude == '0)
        else $error("short run reported a nonzero peak");

endmodule

// ===== tb/sliding_nyquist_peak_search_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding Nyquist peak search checker
// Watches the configuration port and both streams. It tracks the alternating
// window sum, the peak and its start for every accepted sample. It compares
// each report from the block with the oldest predicted one.
// ----------------------------------------------------------------------------
module sliding_nyquist_peak_search_checker
    import snps_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    input  logic             s_ready,
    input  in_t              s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  out_t             m_data,
    output int               mismatch_count,
    output int               pending_reports
);

    localparam int REPORT_LIMIT = 10;

    logic signed [SAMPLE_W-1:0] history [WINDOW_MAX];
    logic [ADDR_W-1:0]          wr_ptr;
    logic signed [SUM_W-1:0]    nyq_sum;
    logic [POS_W-1:0]           pos;
    logic [ABS_W-1:0]           peak_mag;
    logic [POS_W-1:0]           peak_pos;
    logic [LEN_W-1:0]           fill;
    logic [CFG_W-1:0]           len_reg;
    out_t                       peak_reports [$];

    function automatic logic [LEN_W-1:0] active_length();
        if (len_reg == '0) begin
            return LEN_W'(1);
        end
        if (len_reg > CFG_W'(WINDOW_MAX)) begin
            return LEN_W'(WINDOW_MAX);
        end
        return LEN_W'(len_reg);
    endfunction

    function automatic logic signed [SUM_W-1:0] widen(logic signed [SAMPLE_W-1:0] v);
        return {{(SUM_W - SAMPLE_W){v[SAMPLE_W-1]}}, v};
    endfunction

    task automatic clear_run();
        wr_ptr   = '0;
        nyq_sum  = '0;
        pos      = '0;
        peak_mag = '0;
        peak_pos = '0;
        fill     = '0;
    endtask

    task automatic advance_window(input in_t smp);
        logic [LEN_W-1:0]        n;
        logic [ADDR_W-1:0]       rd;
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] old;
        logic [ABS_W-1:0]        mag;
        out_t                    rpt;
        n = active_length();
        x = widen(smp.sample);
        // The oldest sample leaves the window once the window is full.
        if (fill >= n) begin
            rd  = wr_ptr - ADDR_W'(n);
            old = widen(history[rd]);
            if (pos[0] ^ n[0]) begin
                nyq_sum = nyq_sum + old;
            end else begin
                nyq_sum = nyq_sum - old;
            end
        end
        nyq_sum = pos[0] ? nyq_sum - x : nyq_sum + x;
        history[wr_ptr] = smp.sample;
        wr_ptr = wr_ptr + 1'b1;
        if (fill < LEN_W'(WINDOW_MAX)) begin
            fill = fill + 1'b1;
        end
        if (fill >= n) begin
            mag = (nyq_sum < 0) ? -nyq_sum : nyq_sum;
            if (mag > peak_mag) begin
                peak_mag = mag;
                peak_pos = pos + POS_W'(1) - POS_W'(n);
            end
        end
        if (!smp.last) begin
            pos = pos + 1'b1;
        end else begin
            if (fill >= n) begin
                rpt.found          = 1'b1;
                rpt.best_start     = START_W'(peak_pos);
                rpt.best_magnitude = ((peak_mag >> MAG_W) != 0) ? '1 : peak_mag[MAG_W-1:0];
            end else begin
                rpt = '0;
            end
            peak_reports.push_back(rpt);
            clear_run();
        end
    endtask

    task automatic check_report(input out_t got);
        out_t want;
        if (peak_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("%0t: unexpected report found=%0d start=%0d mag=%0d",
                         $realtime, got.found, got.best_start, got.best_magnitude);
            end
        end else begin
            want = peak_reports.pop_front();
            if (got.found !== want.found || got.best_start !== want.best_start ||
                got.best_magnitude !== want.best_magnitude) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("%0t: report mismatch, expected found=%0d start=%0d mag=%0d",
                             $realtime, want.found, want.best_start, want.best_magnitude);
                    $display("%0t:                  got found=%0d start=%0d mag=%0d",
                             $realtime, got.found, got.best_start, got.best_magnitude);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            len_reg = LEN_RESET;
            clear_run();
            peak_reports.delete();
            mismatch_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                check_report(m_data);
            end
            if (cfg_wr_en) begin
                len_reg = cfg_wr_data;
                clear_run();
            end
            if (s_valid && s_ready) begin
                advance_window(s_data);
            end
        end
        pending_reports = peak_reports.size();
    end

endmodule

// ===== tb/sliding_nyquist_peak_search_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding Nyquist peak search testbench
// Drives runs of samples at several window lengths, from directed corner
// cases to long random traffic with bursty source gaps and sink stalls.
// The checker beside the block predicts every report and counts mismatches.
// ----------------------------------------------------------------------------
module sliding_nyquist_peak_search_top_tb;
    import snps_pkg::*;

    localparam int RANDOM_ITEMS  = 1100;
    localparam int CALM_ITEMS    = 250;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 16;
    localparam int QUIET_LIMIT   = 1000;

    typedef enum {PAT_RANDOM, PAT_EXTREME, PAT_ALIGNED, PAT_ZERO, PAT_SMALL} pattern_t;

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    logic             s_valid;
    logic             s_ready;
    in_t              s_data;
    logic             m_valid;
    logic             m_ready;
    out_t             m_data;

    int mismatch_count;
    int pending_reports;
    int samples_sent;
    int quiet_cycles;
    bit src_gaps;
    bit sink_stalls;

    sliding_nyquist_peak_search_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    sliding_nyquist_peak_search_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatch_count  (mismatch_count),
        .pending_reports (pending_reports)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_stalls && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] make_sample(int idx, pattern_t pat);
        int v;
        case (pat)
            PAT_EXTREME: begin
                v = $urandom_range(0, 1) ? 127 : -128;
            end
            PAT_ALIGNED: begin
                v = idx[0] ? -int'($urandom_range(100, 128)) : int'($urandom_range(100, 127));
            end
            PAT_SMALL: begin
                v = int'($urandom_range(0, 6)) - 3;
            end
            PAT_ZERO: begin
                v = 0;
            end
            default: begin
                v = int'($urandom_range(0, 255));
            end
        endcase
        return SAMPLE_W'(v);
    endfunction

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{sample: smp, last: lst};
        // The request holds until the block takes it.
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        samples_sent++;
    endtask

    task automatic send_run(input int count, input pattern_t pat);
        for (int i = 0; i < count; i++) begin
            push_sample(make_sample(i, pat), i == count - 1);
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_reports != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic configure_window(input int value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : stimulus
        int       random_base;
        int       cfg_value;
        int       eff;
        int       run_len;
        int       pick;
        pattern_t pat;

        aclk         = 1'b0;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_data       = '0;
        samples_sent = 0;
        quiet_cycles = 0;
        src_gaps     = 1'b1;
        sink_stalls  = 1'b1;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // The reset length is 4096, so this run is too short for a window.
        send_run(5, PAT_EXTREME);

        configure_window(1);
        push_sample(8'sd127, 1'b0);
        push_sample(-8'sd128, 1'b0);
        push_sample(8'sd0, 1'b0);
        push_sample(-8'sd1, 1'b0);
        push_sample(8'sd1, 1'b1);

        // A zero length behaves as one; equal peaks keep the earliest start.
        configure_window(0);
        push_sample(-8'sd128, 1'b1);
        push_sample(8'sd3, 1'b0);
        push_sample(8'sd3, 1'b0);
        push_sample(-8'sd3, 1'b1);

        configure_window(2);
        send_run(6, PAT_ALIGNED);
        push_sample(8'sd5, 1'b1);

        configure_window(3);
        send_run(4, PAT_ZERO);

        // A length write in the middle of a run starts the run over.
        push_sample(8'sd100, 1'b0);
        push_sample(-8'sd100, 1'b0);
        configure_window(2);
        send_run(3, PAT_EXTREME);

        configure_window(200);
        send_run(260, PAT_ALIGNED);
        configure_window(199);
        send_run(320, PAT_RANDOM);
        configure_window(8191);
        send_run(10, PAT_EXTREME);

        random_base = samples_sent;
        while (samples_sent - random_base < RANDOM_ITEMS) begin
            if (samples_sent - random_base >= RANDOM_ITEMS - CALM_ITEMS) begin
                src_gaps    = 1'b0;
                sink_stalls = 1'b0;
            end else begin
                src_gaps    = $urandom_range(0, 3) != 0;
                sink_stalls = $urandom_range(0, 3) != 0;
            end
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                cfg_value = 0;
            end else if (pick == 1) begin
                cfg_value = WINDOW_MAX + $urandom_range(0, 4095);
            end else if (pick == 2) begin
                cfg_value = $urandom_range(64, WINDOW_MAX);
            end else begin
                cfg_value = $urandom_range(1, 40);
            end
            eff = (cfg_value == 0) ? 1 : (cfg_value > WINDOW_MAX) ? WINDOW_MAX : cfg_value;
            configure_window(cfg_value);
            repeat ($urandom_range(2, 6)) begin
                if (eff <= 64) begin
                    run_len = $urandom_range(1, 2 * eff + 10);
                end else begin
                    run_len = $urandom_range(1, 60);
                end
                pick = $urandom_range(0, 7);
                pat  = (pick > 4) ? PAT_RANDOM : pattern_t'(pick);
                send_run(run_len, pat);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
